>>> hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Store geometry, node encoding, operation codes and the node memory port.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LEAF_BLOCKS = 1024;
    localparam int ROOT_LEVEL  = $clog2(LEAF_BLOCKS);
    localparam int NODES       = (2 ** (ROOT_LEVEL + 1)) - 1;
    localparam int IDX_W       = ROOT_LEVEL + 1;
    localparam int LVL_W       = $clog2(ROOT_LEVEL + 2);
    localparam int BLK_W       = ROOT_LEVEL;

    localparam int BYTES_W     = 32;
    localparam int CFG_W       = 5;
    localparam logic [CFG_W-1:0] BLOCK_LOG2_RESET = 5'd12;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [LVL_W-1:0] lvl_t;
    typedef logic [BLK_W-1:0] blk_t;

    // node value is stored as (log2 of largest free run) + 1; 0 marks allocated
    localparam lvl_t ENC_ALLOC = '0;

    typedef struct packed {
        logic we;
        idx_t waddr;
        lvl_t wdata;
        idx_t raddr_a;
        idx_t raddr_b;
    } mem_req_t;

endpackage

>>> hw/rtl/bba_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [bba_pkg::BYTES_W-1:0] request_bytes;
    logic [bba_pkg::BYTES_W-1:0] offset_bytes;

    modport source (output valid, mode, request_bytes, offset_bytes, input ready);
    modport sink   (input valid, mode, request_bytes, offset_bytes, output ready);
endinterface

>>> hw/rtl/bba_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       success;
    logic [bba_pkg::BYTES_W-1:0] address;

    modport source (output valid, success, address, input ready);
    modport sink   (input valid, success, address, output ready);
endinterface

>>> hw/rtl/bba_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator configuration channel
// Valid/ready write channel for the block size register.
// ----------------------------------------------------------------------------
interface bba_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [bba_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/bba_tree_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator node memory
// One write port, two registered read ports over the implicit tree.
// ----------------------------------------------------------------------------
module bba_tree_mem
(
    input  logic              clk,
    input  bba_pkg::mem_req_t mem_req,
    output bba_pkg::lvl_t     rdata_a,
    output bba_pkg::lvl_t     rdata_b
);

    bba_pkg::lvl_t tree_mem [bba_pkg::NODES];
    bba_pkg::lvl_t rd_a_reg;
    bba_pkg::lvl_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            tree_mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd_a_reg <= tree_mem[mem_req.raddr_a];
        rd_b_reg <= tree_mem[mem_req.raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

>>> hw/rtl/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator control
// Clearing pass, request sizing, tree descent and ancestor update sequencer.
// ----------------------------------------------------------------------------
module bba_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    bba_req_if.sink           req,
    bba_rsp_if.source         rsp,
    bba_cfg_if.sink           cfg,
    output bba_pkg::mem_req_t mem_req,
    input  bba_pkg::lvl_t     rdata_a,
    input  bba_pkg::lvl_t     rdata_b
);

    localparam int CNT_W = bba_pkg::BYTES_W + 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SIZE,
        ST_ACHK,
        ST_ADESC,
        ST_FDESC,
        ST_MARK,
        ST_ASC,
        ST_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [bba_pkg::CFG_W-1:0]    log2_reg, log2_next;
    logic                         mode_reg, mode_next;
    logic [bba_pkg::BYTES_W-1:0]  req_bytes_reg, req_bytes_next;
    logic [bba_pkg::BYTES_W-1:0]  off_bytes_reg, off_bytes_next;
    logic [CNT_W-1:0]             blocks_reg, blocks_next;
    bba_pkg::blk_t                off_reg, off_next;
    logic                         off_big_reg, off_big_next;
    bba_pkg::lvl_t                p_reg, p_next;
    bba_pkg::idx_t                idx_reg, idx_next;
    bba_pkg::lvl_t                lvl_reg, lvl_next;
    bba_pkg::blk_t                blk_reg, blk_next;
    bba_pkg::lvl_t                cur_reg, cur_next;
    logic                         merge_reg, merge_next;
    logic                         succ_reg, succ_next;
    logic [bba_pkg::BYTES_W-1:0]  addr_reg, addr_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic                         rsp_success_reg, rsp_success_next;
    logic [bba_pkg::BYTES_W-1:0]  rsp_address_reg, rsp_address_next;
    bba_pkg::idx_t                clr_idx_reg, clr_idx_next;
    bba_pkg::lvl_t                clr_lvl_reg, clr_lvl_next;

    bba_pkg::idx_t                lft;
    bba_pkg::idx_t                rgt;
    bba_pkg::idx_t                par;
    bba_pkg::lvl_t                lvl_m1;
    bba_pkg::blk_t                half;
    bba_pkg::idx_t                low_mask;
    logic                         off_low_zero;
    bba_pkg::blk_t                off_shr;
    logic [bba_pkg::BYTES_W-1:0]  byte_mask;
    logic [bba_pkg::BYTES_W-1:0]  off_full;
    logic [CNT_W-1:0]             blocks_nz;
    bba_pkg::blk_t                blocks_m1;
    bba_pkg::lvl_t                p_calc;
    logic [bba_pkg::IDX_W:0]      clr_t1;
    logic [bba_pkg::IDX_W:0]      clr_t2;
    bba_pkg::lvl_t                asc_val;
    logic                         asc_eq;

    function automatic bba_pkg::idx_t buddy_of(bba_pkg::idx_t n);
        buddy_of = n[0] ? (n + bba_pkg::IDX_W'(1)) : (n - bba_pkg::IDX_W'(1));
    endfunction

    function automatic bba_pkg::idx_t parent_of(bba_pkg::idx_t n);
        parent_of = (n - bba_pkg::IDX_W'(1)) >> 1;
    endfunction

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.success = rsp_success_reg;
    assign rsp.address = rsp_address_reg;

    assign lft          = {idx_reg[bba_pkg::IDX_W-2:0], 1'b1};
    assign rgt          = lft + bba_pkg::IDX_W'(1);
    assign par          = parent_of(idx_reg);
    assign lvl_m1       = lvl_reg - bba_pkg::LVL_W'(1);
    assign half         = bba_pkg::BLK_W'(1) << lvl_m1;
    assign low_mask     = (bba_pkg::IDX_W'(1) << lvl_reg) - bba_pkg::IDX_W'(1);
    assign off_low_zero = (({1'b0, off_reg} & low_mask) == '0);
    assign off_shr      = off_reg >> lvl_m1;

    assign byte_mask = (bba_pkg::BYTES_W'(1) << log2_reg) - bba_pkg::BYTES_W'(1);
    assign off_full  = off_bytes_reg >> log2_reg;
    assign blocks_nz = (blocks_reg == '0) ? CNT_W'(1) : blocks_reg;
    assign blocks_m1 = bba_pkg::BLK_W'(blocks_nz - CNT_W'(1));

    always_comb
    begin
        p_calc = '0;
        for (int k = 0; k < bba_pkg::BLK_W; k++)
        begin
            if (blocks_m1[k])
            begin
                p_calc = bba_pkg::LVL_W'(k + 1);
            end
        end
    end

    assign clr_t1 = {1'b0, clr_idx_reg} + (bba_pkg::IDX_W + 1)'(1);
    assign clr_t2 = clr_t1 + (bba_pkg::IDX_W + 1)'(1);

    // merge while buddies match in a free, plain max once they stop and in an allocate
    assign asc_eq  = (rdata_a == cur_reg);
    assign asc_val = (merge_reg && asc_eq) ? (cur_reg + bba_pkg::LVL_W'(1))
                   : ((rdata_a > cur_reg) ? rdata_a : cur_reg);

    always_comb
    begin
        state_next       = state_reg;
        log2_next        = log2_reg;
        mode_next        = mode_reg;
        req_bytes_next   = req_bytes_reg;
        off_bytes_next   = off_bytes_reg;
        blocks_next      = blocks_reg;
        off_next         = off_reg;
        off_big_next     = off_big_reg;
        p_next           = p_reg;
        idx_next         = idx_reg;
        lvl_next         = lvl_reg;
        blk_next         = blk_reg;
        cur_next         = cur_reg;
        merge_next       = merge_reg;
        succ_next        = succ_reg;
        addr_next        = addr_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_success_next = rsp_success_reg;
        rsp_address_next = rsp_address_reg;
        clr_idx_next     = clr_idx_reg;
        clr_lvl_next     = clr_lvl_reg;

        mem_req.we      = 1'b0;
        mem_req.waddr   = idx_reg;
        mem_req.wdata   = cur_reg;
        mem_req.raddr_a = '0;
        mem_req.raddr_b = '0;

        if (cfg.valid)
        begin
            log2_next = cfg.data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_idx_reg;
                mem_req.wdata = clr_lvl_reg + bba_pkg::LVL_W'(1);
                if (clr_idx_reg == bba_pkg::IDX_W'(bba_pkg::NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + bba_pkg::IDX_W'(1);
                    if ((clr_t1 & clr_t2) == '0)
                    begin
                        clr_lvl_next = clr_lvl_reg - bba_pkg::LVL_W'(1);
                    end
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next      = req.mode;
                    req_bytes_next = req.request_bytes;
                    off_bytes_next = req.offset_bytes;
                    state_next     = ST_PREP;
                end
            end

            ST_PREP:
            begin
                blocks_next  = {1'b0, req_bytes_reg >> log2_reg}
                             + CNT_W'(|(req_bytes_reg & byte_mask));
                off_next     = off_full[bba_pkg::BLK_W-1:0];
                off_big_next = |off_full[bba_pkg::BYTES_W-1:bba_pkg::BLK_W];
                idx_next     = '0;
                lvl_next     = bba_pkg::LVL_W'(bba_pkg::ROOT_LEVEL);
                blk_next     = '0;
                succ_next    = 1'b0;
                addr_next    = '0;
                state_next   = (mode_reg == bba_pkg::MODE_FREE) ? ST_FDESC : ST_SIZE;
            end

            ST_SIZE:
            begin
                p_next = p_calc;
                if (blocks_nz > (CNT_W'(1) << bba_pkg::ROOT_LEVEL))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ACHK;
                end
            end

            ST_ACHK:
            begin
                if (rdata_a <= p_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_req.raddr_a = lft;
                    mem_req.raddr_b = rgt;
                    state_next      = ST_ADESC;
                end
            end

            ST_ADESC:
            begin
                if ((rdata_a > p_reg) || (rdata_b > p_reg))
                begin
                    if (rdata_a > p_reg)
                    begin
                        idx_next = lft;
                    end
                    else
                    begin
                        idx_next = rgt;
                        blk_next = blk_reg + half;
                    end
                    lvl_next = lvl_m1;
                    if (lvl_m1 == '0)
                    begin
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        mem_req.raddr_a = {idx_next[bba_pkg::IDX_W-2:0], 1'b1};
                        mem_req.raddr_b = {idx_next[bba_pkg::IDX_W-2:0], 1'b1}
                                        + bba_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_MARK;
                end
                if (state_next == ST_MARK)
                begin
                    cur_next   = bba_pkg::ENC_ALLOC;
                    merge_next = 1'b0;
                    succ_next  = 1'b1;
                    addr_next  = bba_pkg::BYTES_W'(blk_next) << log2_reg;
                end
            end

            ST_FDESC:
            begin
                priority if (off_big_reg)
                begin
                    state_next = ST_DONE;
                end
                else if ((rdata_a == bba_pkg::ENC_ALLOC) && off_low_zero)
                begin
                    cur_next   = lvl_reg + bba_pkg::LVL_W'(1);
                    merge_next = 1'b1;
                    succ_next  = 1'b1;
                    state_next = ST_MARK;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next        = off_shr[0] ? rgt : lft;
                    lvl_next        = lvl_m1;
                    mem_req.raddr_a = idx_next;
                end
            end

            ST_MARK:
            begin
                mem_req.we = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_req.raddr_a = buddy_of(idx_reg);
                    state_next      = ST_ASC;
                end
            end

            ST_ASC:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = par;
                mem_req.wdata = asc_val;
                cur_next      = asc_val;
                merge_next    = merge_reg && asc_eq;
                idx_next      = par;
                if (par == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_req.raddr_a = buddy_of(par);
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_success_next = succ_reg;
                    rsp_address_next = addr_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            log2_reg        <= bba_pkg::BLOCK_LOG2_RESET;
            mode_reg        <= bba_pkg::MODE_ALLOC;
            req_bytes_reg   <= '0;
            off_bytes_reg   <= '0;
            blocks_reg      <= '0;
            off_reg         <= '0;
            off_big_reg     <= 1'b0;
            p_reg           <= '0;
            idx_reg         <= '0;
            lvl_reg         <= '0;
            blk_reg         <= '0;
            cur_reg         <= '0;
            merge_reg       <= 1'b0;
            succ_reg        <= 1'b0;
            addr_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_success_reg <= 1'b0;
            rsp_address_reg <= '0;
            clr_idx_reg     <= '0;
            clr_lvl_reg     <= bba_pkg::LVL_W'(bba_pkg::ROOT_LEVEL);
        end
        else
        begin
            state_reg       <= state_next;
            log2_reg        <= log2_next;
            mode_reg        <= mode_next;
            req_bytes_reg   <= req_bytes_next;
            off_bytes_reg   <= off_bytes_next;
            blocks_reg      <= blocks_next;
            off_reg         <= off_next;
            off_big_reg     <= off_big_next;
            p_reg           <= p_next;
            idx_reg         <= idx_next;
            lvl_reg         <= lvl_next;
            blk_reg         <= blk_next;
            cur_reg         <= cur_next;
            merge_reg       <= merge_next;
            succ_reg        <= succ_next;
            addr_reg        <= addr_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_success_reg <= rsp_success_next;
            rsp_address_reg <= rsp_address_next;
            clr_idx_reg     <= clr_idx_next;
            clr_lvl_reg     <= clr_lvl_next;
        end
    end

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK && mode_reg == bba_pkg::MODE_ALLOC)
        |-> (({1'b0, blk_reg} & low_mask) == '0))
        else $error("allocated block not aligned to its size");

    a_asc_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ASC && mem_req.waddr != '0)
        |-> (mem_req.raddr_a != mem_req.waddr))
        else $error("ascent reads the node it writes");

    a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ASC) |=> (state_reg == ST_ASC || state_reg == ST_DONE))
        else $error("ascent left without completing");

endmodule

>>> hw/rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over a tree of free-run sizes held in node memory.
// ----------------------------------------------------------------------------
// One request at a time. With L = log2 of the store in blocks (10 for 1024
// blocks), the descent visits one tree level per cycle, an allocate reading
// both children at once on the node memory's two read ports and a free one
// node, and the ancestor update writes one level per cycle. A result waits in
// an output register, so the next request is taken once the sequencer is idle,
// which is in the cycle the result is first presented. After reset a clearing
// pass writes every one of the 2^(L+1) - 1 nodes, during which no request is
// taken; block size writes are accepted at any time.
module buddy_block_allocator
(
    input  logic      clk,
    input  logic      rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp,
    bba_cfg_if.sink   cfg
);

    bba_pkg::mem_req_t mem_req;
    bba_pkg::lvl_t     rdata_a;
    bba_pkg::lvl_t     rdata_b;

    bba_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .cfg     (cfg),
        .mem_req (mem_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    bba_tree_mem u_tree_mem
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

endmodule
